// ===== src/cau_pkg.sv =====
// shared types and constants for the complex arithmetic unit
// no dependencies; imported by every module of the block
package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_MAG = 2'd3
  } cau_op_e;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  // root bits resolved per sqrt pipeline stage
  localparam int SQRT_STEPS = 4;

  function automatic int cau_sqrt_stages(input int w);
    return (w + SQRT_STEPS - 1) / SQRT_STEPS;
  endfunction

  // pipeline depth from start to done: product, sum, clip stages plus the sqrt stages
  function automatic int cau_latency(input int w);
    return 3 + cau_sqrt_stages(w);
  endfunction

endpackage

// ===== src/cau_mul.sv =====
// product and sum stages: four signed multipliers, then the cross sums
// and the sum of squares; depends on cau_pkg
module cau_mul
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vld_i,
  input  cau_op_e                      op_i,
  input  logic signed [DATA_WIDTH-1:0] a_re_i,
  input  logic signed [DATA_WIDTH-1:0] a_im_i,
  input  logic signed [DATA_WIDTH-1:0] b_re_i,
  input  logic signed [DATA_WIDTH-1:0] b_im_i,
  output logic                         vld_o,
  output cau_op_e                      op_o,
  output logic signed [2*DATA_WIDTH:0] re_sum_o,
  output logic signed [2*DATA_WIDTH:0] im_sum_o,
  output logic [2*DATA_WIDTH-1:0]      sq_o
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH;
  localparam int SW = 2 * DATA_WIDTH + 1;

  // stage 1
  logic                 vld1_q;
  cau_op_e              op1_q;
  logic signed [W-1:0]  y0, y1;
  logic signed [PW-1:0] p0_d, p1_d, p2_d, p3_d;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [W:0]    as_re_d, as_im_d, as_re_q, as_im_q;

  // stage 2
  logic                 vld2_q;
  cau_op_e              op2_q;
  logic signed [SW-1:0] re_d, im_d, re_q, im_q;
  logic [PW-1:0]        sq_d, sq_q;

  // magnitude squares the first operand on the same two multipliers
  assign y0 = (op_i == OP_MAG) ? a_re_i : b_re_i;
  assign y1 = (op_i == OP_MAG) ? a_im_i : b_im_i;

  assign p0_d = a_re_i * y0;
  assign p1_d = a_im_i * y1;
  assign p2_d = a_re_i * b_im_i;
  assign p3_d = a_im_i * b_re_i;

  always_comb begin
    if (op_i == OP_SUB) begin
      as_re_d = {a_re_i[W-1], a_re_i} - {b_re_i[W-1], b_re_i};
      as_im_d = {a_im_i[W-1], a_im_i} - {b_im_i[W-1], b_im_i};
    end else begin
      as_re_d = {a_re_i[W-1], a_re_i} + {b_re_i[W-1], b_re_i};
      as_im_d = {a_im_i[W-1], a_im_i} + {b_im_i[W-1], b_im_i};
    end
  end

  always_comb begin
    if (op1_q == OP_MUL) begin
      re_d = {p0_q[PW-1], p0_q} - {p1_q[PW-1], p1_q};
      im_d = {p2_q[PW-1], p2_q} + {p3_q[PW-1], p3_q};
    end else begin
      re_d = {{(SW-W-1){as_re_q[W]}}, as_re_q};
      im_d = {{(SW-W-1){as_im_q[W]}}, as_im_q};
    end
  end

  // both squares are non-negative and their sum fits in PW bits
  assign sq_d = $unsigned(p0_q) + $unsigned(p1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q   <= op_i;
    p0_q    <= p0_d;
    p1_q    <= p1_d;
    p2_q    <= p2_d;
    p3_q    <= p3_d;
    as_re_q <= as_re_d;
    as_im_q <= as_im_d;
    op2_q   <= op1_q;
    re_q    <= re_d;
    im_q    <= im_d;
    sq_q    <= sq_d;
  end

  assign vld_o    = vld2_q;
  assign op_o     = op2_q;
  assign re_sum_o = re_q;
  assign im_sum_o = im_q;
  assign sq_o     = sq_q;

endmodule

// ===== src/cau_sat.sv =====
// scaling and saturation stage: product shift, clip to the word width,
// zeroing of unused fields; depends on cau_pkg
module cau_sat
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vld_i,
  input  cau_op_e                      op_i,
  input  logic signed [2*DATA_WIDTH:0] re_sum_i,
  input  logic signed [2*DATA_WIDTH:0] im_sum_i,
  input  logic [2*DATA_WIDTH-1:0]      sq_i,
  output logic                         vld_o,
  output logic [DATA_WIDTH-1:0]        res_re_o,
  output logic [DATA_WIDTH-1:0]        res_im_o,
  output logic                         sat_o,
  output logic [2*DATA_WIDTH-1:0]      sq_o
);

  localparam int W  = DATA_WIDTH;
  localparam int SW = 2 * DATA_WIDTH + 1;

  logic signed [SW-1:0] re_sh, im_sh;
  logic                 re_ovf, im_ovf;
  logic [W-1:0]         re_clip, im_clip;
  logic                 vld_q, sat_d, sat_q;
  logic [W-1:0]         re_d, im_d, re_q, im_q;
  logic [2*W-1:0]       sq_d, sq_q;

  // arithmetic shift floors toward minus infinity
  assign re_sh = (op_i == OP_MUL) ? (re_sum_i >>> FRAC_BITS) : re_sum_i;
  assign im_sh = (op_i == OP_MUL) ? (im_sum_i >>> FRAC_BITS) : im_sum_i;

  // out of range when the bits above the word are not a sign extension
  assign re_ovf = !((&re_sh[SW-1:W-1]) || !(|re_sh[SW-1:W-1]));
  assign im_ovf = !((&im_sh[SW-1:W-1]) || !(|im_sh[SW-1:W-1]));

  assign re_clip = re_ovf ? {re_sh[SW-1], {(W-1){~re_sh[SW-1]}}} : re_sh[W-1:0];
  assign im_clip = im_ovf ? {im_sh[SW-1], {(W-1){~im_sh[SW-1]}}} : im_sh[W-1:0];

  always_comb begin
    if (op_i == OP_MAG) begin
      re_d  = '0;
      im_d  = '0;
      sat_d = 1'b0;
      sq_d  = sq_i;
    end else begin
      re_d  = re_clip;
      im_d  = im_clip;
      sat_d = re_ovf | im_ovf;
      sq_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    re_q  <= re_d;
    im_q  <= im_d;
    sat_q <= sat_d;
    sq_q  <= sq_d;
  end

  assign vld_o    = vld_q;
  assign res_re_o = re_q;
  assign res_im_o = im_q;
  assign sat_o    = sat_q;
  assign sq_o     = sq_q;

endmodule

// ===== src/cau_sqrt.sv =====
// pipelined restoring square root, SQRT_STEPS root bits per stage,
// with a sideband word carried alongside; depends on cau_pkg
module cau_sqrt
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int SIDE_W     = 2 * DATA_WIDTH_DEF + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  input  logic [2*DATA_WIDTH-1:0] rad_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    vld_o,
  output logic [DATA_WIDTH-1:0]   root_o,
  output logic [SIDE_W-1:0]       side_o
);

  localparam int W  = DATA_WIDTH;
  localparam int NS = cau_sqrt_stages(DATA_WIDTH);

  logic [2*W-1:0]    rad_q  [NS];
  logic [W+1:0]      rem_q  [NS];
  logic [W-1:0]      root_q [NS];
  logic [SIDE_W-1:0] side_q [NS];
  logic [NS-1:0]     vld_q;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [2*W-1:0]    rad_in;
    logic [W+1:0]      rem_in;
    logic [W-1:0]      root_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [2*W-1:0]    rad_d;
    logic [W+1:0]      rem_d;
    logic [W-1:0]      root_d;

    if (s == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    always_comb begin
      logic [W+3:0] rem_sh;
      logic [W+3:0] trial;
      rad_d  = rad_in;
      rem_d  = rem_in;
      root_d = root_in;
      rem_sh = '0;
      trial  = '0;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        if (s * SQRT_STEPS + k < W) begin
          rem_sh = {rem_d, rad_d[2*W-1:2*W-2]};
          trial  = {2'b00, root_d, 2'b01};
          if (rem_sh >= trial) begin
            rem_sh = rem_sh - trial;
            root_d = {root_d[W-2:0], 1'b1};
          end else begin
            root_d = {root_d[W-2:0], 1'b0};
          end
          rem_d = rem_sh[W+1:0];
          rad_d = {rad_d[2*W-3:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[s]  <= rad_d;
      rem_q[s]  <= rem_d;
      root_q[s] <= root_d;
      side_q[s] <= side_in;
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign root_o = root_q[NS-1];
  assign side_o = side_q[NS-1];

endmodule

// ===== src/complex_arithmetic_unit.sv =====
// complex arithmetic unit: product, sum and clip stages, then a square-root pipeline whose depth
// grows with DATA_WIDTH, as it resolves 4 root bits a stage
// throughput one word per clock; busy stays low and results are never held back
// asynchronous active-low reset clears every valid bit, data registers are not reset
// depends on cau_pkg, cau_mul, cau_sat, cau_sqrt
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type_i,
  input  logic signed [DATA_WIDTH-1:0] a_re_i,
  input  logic signed [DATA_WIDTH-1:0] a_im_i,
  input  logic signed [DATA_WIDTH-1:0] b_re_i,
  input  logic signed [DATA_WIDTH-1:0] b_im_i,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] res_re_o,
  output logic signed [DATA_WIDTH-1:0] res_im_o,
  output logic [DATA_WIDTH-1:0]        magnitude_o,
  output logic                         saturated_o
);

  localparam int W      = DATA_WIDTH;
  localparam int SIDE_W = 2 * DATA_WIDTH + 1;

  // the pipeline never stalls, so a word is taken on every start
  logic    accept;
  cau_op_e op_in;

  // product/sum stages to clip stage
  logic                mul_vld;
  cau_op_e             mul_op;
  logic signed [2*W:0] mul_re, mul_im;
  logic [2*W-1:0]      mul_sq;

  // clip stage to sqrt pipeline
  logic                sat_vld;
  logic [W-1:0]        sat_re, sat_im;
  logic                sat_flag;
  logic [2*W-1:0]      sat_sq;

  // sqrt pipeline outputs, clipped results travel as sideband
  logic                sq_vld;
  logic [W-1:0]        sq_root;
  logic [SIDE_W-1:0]   sq_side;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_comb begin
    case (req_type_i)
      2'd0:    op_in = OP_ADD;
      2'd1:    op_in = OP_SUB;
      2'd2:    op_in = OP_MUL;
      default: op_in = OP_MAG;
    endcase
  end

  // stages 1-2: four multipliers, then the cross sums and sum of squares
  cau_mul #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (accept),
    .op_i    (op_in),
    .a_re_i  (a_re_i),
    .a_im_i  (a_im_i),
    .b_re_i  (b_re_i),
    .b_im_i  (b_im_i),
    .vld_o   (mul_vld),
    .op_o    (mul_op),
    .re_sum_o(mul_re),
    .im_sum_o(mul_im),
    .sq_o    (mul_sq)
  );

  // stage 3: fraction shift for products, saturation, unused fields cleared
  cau_sat #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (mul_vld),
    .op_i    (mul_op),
    .re_sum_i(mul_re),
    .im_sum_i(mul_im),
    .sq_i    (mul_sq),
    .vld_o   (sat_vld),
    .res_re_o(sat_re),
    .res_im_o(sat_im),
    .sat_o   (sat_flag),
    .sq_o    (sat_sq)
  );

  // remaining stages: root of the sum of squares, zero radicand gives zero
  // magnitude for the non-magnitude ops; last stage doubles as output register
  cau_sqrt #(
    .DATA_WIDTH(DATA_WIDTH),
    .SIDE_W    (SIDE_W)
  ) u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (sat_vld),
    .rad_i (sat_sq),
    .side_i({sat_re, sat_im, sat_flag}),
    .vld_o (sq_vld),
    .root_o(sq_root),
    .side_o(sq_side)
  );

  assign done        = sq_vld;
  assign magnitude_o = sq_root;
  assign res_re_o    = sq_side[SIDE_W-1 -: W];
  assign res_im_o    = sq_side[W:1];
  assign saturated_o = sq_side[0];

endmodule

// ===== src/cau_chk.sv =====
// port-level checker for the complex arithmetic unit, bound to the top level
// depends on cau_pkg and complex_arithmetic_unit
module cau_chk
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic [1:0]            req_type_i,
  input logic                  done,
  input logic [DATA_WIDTH-1:0] res_re_o,
  input logic [DATA_WIDTH-1:0] res_im_o,
  input logic [DATA_WIDTH-1:0] magnitude_o,
  input logic                  saturated_o
);

  localparam int LAT = cau_latency(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] max_v, min_v;
  assign max_v = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  assign min_v = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LAT done)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> $past(start && !busy, LAT))
    else $error("result without an accepted word");

  a_mag_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_type_i == OP_MAG |->
      ##LAT (res_re_o == '0 && res_im_o == '0 && !saturated_o))
    else $error("magnitude result carries arithmetic fields");

  a_sat_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && saturated_o |->
      (res_re_o == max_v || res_re_o == min_v || res_im_o == max_v || res_im_o == min_v))
    else $error("saturation flag without a clipped part");

  a_mag_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && magnitude_o != '0 |-> res_re_o == '0 && res_im_o == '0)
    else $error("magnitude alongside a complex result");

endmodule

bind complex_arithmetic_unit cau_chk #(
  .DATA_WIDTH(DATA_WIDTH)
) u_cau_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .req_type_i (req_type_i),
  .done       (done),
  .res_re_o   (res_re_o),
  .res_im_o   (res_im_o),
  .magnitude_o(magnitude_o),
  .saturated_o(saturated_o)
);

// ===== verif/complex_arithmetic_unit_tb.sv =====
// self-checking testbench for complex_arithmetic_unit: directed corner words, then random
// words over several sender idling phases, each result checked against an in-bench predictor
// depends on cau_pkg and the complex_arithmetic_unit rtl
module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;

  localparam logic signed [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};

  // one result word as it leaves the block
  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic [DW-1:0]        magnitude;
    logic                 saturated;
  } cau_result_t;

  // predicts each result word and keeps the ones still in flight
  class cau_scoreboard;
    cau_result_t awaited_results[$];
    int          mismatch_count = 0;

    // clamp to the signed result range, flag any clipping
    function longint clip_part(longint v, inout bit sat);
      longint hi;
      longint lo;
      hi = (longint'(1) << (DW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        sat = 1'b1;
        return hi;
      end
      if (v < lo) begin
        sat = 1'b1;
        return lo;
      end
      return v;
    endfunction

    // floor of the integer square root, two bits of the radicand per pass
    function bit [63:0] int_sqrt(bit [63:0] n);
      bit [63:0] root;
      bit [63:0] one;
      bit [63:0] rem;
      root = '0;
      rem  = n;
      one  = 64'd1 << 62;
      while (one > rem) one >>= 2;
      while (one != 0) begin
        if (rem >= root + one) begin
          rem  = rem - (root + one);
          root = (root >> 1) + one;
        end else begin
          root = root >> 1;
        end
        one >>= 2;
      end
      return root;
    endfunction

    function cau_result_t compute_result(cau_op_e op, logic signed [DW-1:0] ar,
                                         logic signed [DW-1:0] ai, logic signed [DW-1:0] br,
                                         logic signed [DW-1:0] bi);
      cau_result_t r;
      bit          sat;
      longint      lar, lai, lbr, lbi;
      longint      re, im;
      bit [63:0]   sq;
      r   = '0;
      sat = 1'b0;
      lar = ar;
      lai = ai;
      lbr = br;
      lbi = bi;
      re  = 0;
      im  = 0;
      case (op)
        OP_ADD: begin
          re = lar + lbr;
          im = lai + lbi;
        end
        OP_SUB: begin
          re = lar - lbr;
          im = lai - lbi;
        end
        OP_MUL: begin
          // full products, then an arithmetic (floor) shift by the fraction bits
          re = (lar * lbr - lai * lbi) >>> FB;
          im = (lar * lbi + lai * lbr) >>> FB;
        end
        default: begin
          sq = lar * lar + lai * lai;
          r.magnitude = DW'(int_sqrt(sq));
        end
      endcase
      if (op != OP_MAG) begin
        r.res_re    = DW'(clip_part(re, sat));
        r.res_im    = DW'(clip_part(im, sat));
        r.saturated = sat;
      end
      return r;
    endfunction

    function void note_word(cau_op_e op, logic signed [DW-1:0] ar, logic signed [DW-1:0] ai,
                            logic signed [DW-1:0] br, logic signed [DW-1:0] bi);
      awaited_results.push_back(compute_result(op, ar, ai, br, bi));
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_word(cau_result_t got);
      cau_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result word with nothing pending: re %0d im %0d mag %0d sat %0b",
               got.res_re, got.res_im, got.magnitude, got.saturated);
        mismatch_count++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("res_re", want.res_re, got.res_re);
      compare_field("res_im", want.res_im, got.res_im);
      compare_field("magnitude", longint'(want.magnitude), longint'(got.magnitude));
      compare_field("saturated", longint'(want.saturated), longint'(got.saturated));
    endfunction
  endclass

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 start      = 1'b0;
  logic [1:0]           req_type_i = '0;
  logic signed [DW-1:0] a_re_i     = '0;
  logic signed [DW-1:0] a_im_i     = '0;
  logic signed [DW-1:0] b_re_i     = '0;
  logic signed [DW-1:0] b_im_i     = '0;
  logic                 busy;
  logic                 done;
  logic signed [DW-1:0] res_re_o;
  logic signed [DW-1:0] res_im_o;
  logic [DW-1:0]        magnitude_o;
  logic                 saturated_o;

  cau_scoreboard board = new();

  complex_arithmetic_unit #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_type_i (req_type_i),
    .a_re_i     (a_re_i),
    .a_im_i     (a_im_i),
    .b_re_i     (b_re_i),
    .b_im_i     (b_im_i),
    .done       (done),
    .res_re_o   (res_re_o),
    .res_im_o   (res_im_o),
    .magnitude_o(magnitude_o),
    .saturated_o(saturated_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watch both handshakes at the edge, before any nonblocking update of this step lands
  always @(posedge clk_i) begin
    cau_result_t seen;
    if (rst_ni && start && !busy) begin
      board.note_word(cau_op_e'(req_type_i), a_re_i, a_im_i, b_re_i, b_im_i);
    end
    if (rst_ni && done) begin
      seen.res_re    = res_re_o;
      seen.res_im    = res_im_o;
      seen.magnitude = magnitude_o;
      seen.saturated = saturated_o;
      board.check_word(seen);
    end
  end

  // present one word, idling first with the given odds, return at the accepting edge
  task automatic send_word(cau_op_e op, logic signed [DW-1:0] ar, logic signed [DW-1:0] ai,
                           logic signed [DW-1:0] br, logic signed [DW-1:0] bi, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    req_type_i <= op;
    a_re_i     <= ar;
    a_im_i     <= ai;
    b_re_i     <= br;
    b_im_i     <= bi;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // operand values: extremes and near-zero values often, full range otherwise
  function automatic logic signed [DW-1:0] pick_operand();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0: return MAX_VAL;
          1: return MIN_VAL;
          2: return '0;
          3: return DW'(-1);
          default: return DW'(1);
        endcase
      end
      1: return DW'($signed($urandom_range(2048)) - 1024);
      default: return DW'($urandom());
    endcase
  endfunction

  task automatic run_directed();
    // add: clip high, clip low on both parts, and two clean sums
    send_word(OP_ADD, MAX_VAL, 0, MAX_VAL, 0, 0);
    send_word(OP_ADD, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, 0);
    send_word(OP_ADD, 256, -512, 512, 256, 0);
    send_word(OP_ADD, -1, -1, 1, 1, 0);
    // subtract: opposite clipping on the two parts, exact zero, negating the minimum
    send_word(OP_SUB, MIN_VAL, MAX_VAL, MAX_VAL, MIN_VAL, 0);
    send_word(OP_SUB, 100, -100, 100, -100, 0);
    send_word(OP_SUB, 0, 0, MIN_VAL, MIN_VAL, 0);
    // multiply: unity, floor of a negative fraction, i*i, clipping, mixed values
    send_word(OP_MUL, 256, 0, 256, 0, 0);
    send_word(OP_MUL, -1, 0, 1, 0, 0);
    send_word(OP_MUL, 0, 256, 0, 256, 0);
    send_word(OP_MUL, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, 0);
    send_word(OP_MUL, MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL, 0);
    send_word(OP_MUL, MAX_VAL, 0, MIN_VAL, 0, 0);
    send_word(OP_MUL, 384, -640, -200, 77, 0);
    // magnitude: zero, 3-4-5 triangle, largest radicand, smallest nonzero; b is ignored
    send_word(OP_MAG, 0, 0, MAX_VAL, MIN_VAL, 0);
    send_word(OP_MAG, 768, 1024, 0, 0, 0);
    send_word(OP_MAG, MIN_VAL, MIN_VAL, 12345, -321, 0);
    send_word(OP_MAG, MAX_VAL, MAX_VAL, 0, 0, 0);
    send_word(OP_MAG, -1, 0, 1, 1, 0);
    send_word(OP_MAG, MIN_VAL, 0, -5, 5, 0);
  endtask

  // run length guard, far beyond the slowest correct run
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int idle_phase[4];
    int drain_cycles;
    idle_phase = '{0, 78, 0, 20};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // random words: phase with no idling, heavy sender idling, no idling again, light idling
    foreach (idle_phase[p]) begin
      for (int n = 0; n < 208; n++) begin
        send_word(cau_op_e'($urandom_range(3)), pick_operand(), pick_operand(),
                  pick_operand(), pick_operand(), idle_phase[p]);
      end
    end
    start <= 1'b0;

    // let the pipeline drain, then keep watching to catch stray strobes
    drain_cycles = 0;
    while (board.awaited_results.size() != 0 && drain_cycles < 1000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (cau_latency(DW) + 4) @(posedge clk_i);

    if (board.awaited_results.size() != 0) begin
      $error("%0d result words never arrived", board.awaited_results.size());
    end
    if (board.mismatch_count == 0 && board.awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
